// File: src/bitmap_id_allocator_assert.svh
// ---------------------------------------------------------------------------
// bitmap id allocator assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef BITMAP_ID_ALLOCATOR_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BIA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BIA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/bia_pkg.sv
// ---------------------------------------------------------------------------
// bia_pkg
// shared widths, codes and beat types of the bitmap id allocator
// ---------------------------------------------------------------------------
package bia_pkg;

  // default geometry
  localparam int unsigned MAP_BITS_DEF  = 8192;
  localparam int unsigned WORD_BITS_DEF = 64;
  localparam int unsigned FIFO_DEPTH    = 2;
  localparam int unsigned GRP_WORDS_MAX = 16;

  // field widths
  localparam int unsigned ID_W       = 16;
  localparam int unsigned CNT_W      = 14;
  localparam int unsigned LIM_W      = 17;
  localparam int unsigned OPC_W      = 2;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LIM_W-1:0] ID_SPACE = LIM_W'(65536);

  // register reset values
  localparam logic [ID_W-1:0]  BASE_RST  = ID_W'(300);
  localparam logic [CNT_W-1:0] COUNT_RST = CNT_W'(4701);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ID  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ID_COUNT = CFG_IDX_W'(1);

  // opcodes
  localparam logic [OPC_W-1:0] OP_CLEAR   = OPC_W'(0);
  localparam logic [OPC_W-1:0] OP_ALLOC   = OPC_W'(1);
  localparam logic [OPC_W-1:0] OP_RELEASE = OPC_W'(2);

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = ST_W'(0);
  localparam logic [ST_W-1:0] ST_FULL  = ST_W'(1);
  localparam logic [ST_W-1:0] ST_RANGE = ST_W'(2);

  // work classes handed from front to back
  typedef enum logic [1:0] {
    K_CLEAR,
    K_ALLOC,
    K_FREE,
    K_REPLY
  } cmd_kind_e;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [ID_W-1:0]  id_in;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] id_out;
    logic [ST_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  idx;
    logic [LIM_W-1:0] lim;
    logic [ID_W-1:0]  base;
  } cmd_t;

endpackage

// File: src/bia_fifo.sv
// ---------------------------------------------------------------------------
// bia_fifo
// small synchronous queue with push/full and pop/empty sides
// ---------------------------------------------------------------------------
module bia_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // beat storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: src/bia_front.sv
// ---------------------------------------------------------------------------
// bia_front
// configuration registers, active limit and classification of input beats
// ---------------------------------------------------------------------------
module bia_front
  import bia_pkg::*;
#(
  parameter int unsigned MAP_BITS = MAP_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push_i,
  input  in_item_t              in_item_i,
  output logic                  full_o,
  output cmd_t                  cmd_o,
  output logic                  cmd_push_o,
  input  logic                  cmd_full_i
);

  localparam logic [LIM_W-1:0] MapLim = LIM_W'(MAP_BITS);

  logic [ID_W-1:0]  base_q;
  logic [CNT_W-1:0] count_q;
  logic [LIM_W-1:0] room, cap_lim, lim, offset;
  logic             in_range;

  assign cfg_ready_o = 1'b1;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RST;
      count_q <= COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BASE_ID:  base_q  <= cfg_data_i[ID_W-1:0];
        CFG_ID_COUNT: count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // active limit: smallest of count, map size and room left in the id space
  always_comb begin
    room     = ID_SPACE - LIM_W'(base_q);
    cap_lim  = (LIM_W'(count_q) > MapLim) ? MapLim : LIM_W'(count_q);
    lim      = (cap_lim > room) ? room : cap_lim;
    offset   = LIM_W'(in_item_i.id_in) - LIM_W'(base_q);
    in_range = (in_item_i.id_in >= base_q) && (offset < lim);
  end

  // classify the beat for the back end
  always_comb begin
    cmd_o.idx    = offset[ID_W-1:0];
    cmd_o.lim    = lim;
    cmd_o.base   = base_q;
    cmd_o.status = ST_OK;
    cmd_o.kind   = K_REPLY;
    unique case (in_item_i.opcode)
      OP_CLEAR: cmd_o.kind = K_CLEAR;
      OP_ALLOC: cmd_o.kind = K_ALLOC;
      OP_RELEASE: begin
        if (in_range) begin
          cmd_o.kind = K_FREE;
        end else begin
          cmd_o.status = ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  assign cmd_push_o = push_i & ~cmd_full_i;
  assign full_o     = cmd_full_i;

endmodule

// File: src/bia_back.sv
// ---------------------------------------------------------------------------
// bia_back
// bitmap memory, full-word summary and the sequencer that runs commands
// ---------------------------------------------------------------------------
`include "bitmap_id_allocator_assert.svh"

module bia_back
  import bia_pkg::*;
#(
  parameter int unsigned MAP_BITS  = MAP_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_empty_i,
  output logic      cmd_pop_o,
  output out_item_t res_o,
  output logic      res_push_o,
  input  logic      res_full_i
);

  localparam int unsigned WORDS     = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned GRP_WORDS = (WORDS < GRP_WORDS_MAX) ? WORDS : GRP_WORDS_MAX;
  localparam int unsigned NGRP      = (WORDS + GRP_WORDS - 1) / GRP_WORDS;
  localparam int unsigned PAD_WORDS = NGRP * GRP_WORDS;
  localparam int unsigned GIDX_W    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned GOFF_W    = (GRP_WORDS > 1) ? $clog2(GRP_WORDS) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GRP  = 3'd1;
  localparam logic [2:0] S_WORD = 3'd2;
  localparam logic [2:0] S_DATA = 3'd3;
  localparam logic [2:0] S_FREE = 3'd4;

  logic [2:0]           state_q, state_d;
  cmd_t                 cmd_q;
  logic [WORD_BITS-1:0] mem_q [WORDS];
  logic [WORDS-1:0]     full_q, valid_q;
  logic [PAD_WORDS-1:0] full_pad;
  logic [NGRP-1:0]      grp_full;
  logic [GIDX_W-1:0]    grp_q, grp_sel;
  logic                 grp_any;
  logic [GRP_WORDS-1:0] grp_words;
  logic [GOFF_W-1:0]    off_sel;
  logic [WIDX_W-1:0]    word_sel, word_q, raddr;
  logic [WORD_BITS-1:0] rdata_q, cur_word, wdata;
  logic                 rvalid_q;
  logic [BIT_W-1:0]     bit_sel, bit_free;
  logic                 bit_any;
  logic [LIM_W-1:0]     alloc_idx;
  logic                 alloc_ok, start, do_write;

  assign start     = (state_q == S_IDLE) && !cmd_empty_i && !res_full_i;
  assign cmd_pop_o = start;

  // summary padded with full words up to whole groups
  for (genvar i = 0; i < PAD_WORDS; i++) begin : g_pad
    if (i < WORDS) begin : g_real
      assign full_pad[i] = full_q[i];
    end else begin : g_fill
      assign full_pad[i] = 1'b1;
    end
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    assign grp_full[g] = &full_pad[g*GRP_WORDS +: GRP_WORDS];
  end

  // lowest group with a word that is not full
  always_comb begin
    grp_sel = '0;
    grp_any = 1'b0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (!grp_full[g]) begin
        grp_sel = GIDX_W'(g);
        grp_any = 1'b1;
      end
    end
  end

  // lowest non-full word inside the chosen group
  always_comb begin
    grp_words = full_pad[int'(grp_q)*GRP_WORDS +: GRP_WORDS];
    off_sel   = '0;
    for (int w = GRP_WORDS - 1; w >= 0; w--) begin
      if (!grp_words[w]) begin
        off_sel = GOFF_W'(w);
      end
    end
    word_sel = WIDX_W'(int'(grp_q) * GRP_WORDS + int'(off_sel));
  end

  // bitmap word read back, unwritten rows read as free
  assign cur_word = rvalid_q ? rdata_q : '0;

  // lowest free bit in the word read back
  always_comb begin
    bit_sel = '0;
    bit_any = 1'b0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!cur_word[b]) begin
        bit_sel = BIT_W'(b);
        bit_any = 1'b1;
      end
    end
    alloc_idx = (LIM_W'(word_q) << BIT_W) | LIM_W'(bit_sel);
    alloc_ok  = bit_any && (alloc_idx < cmd_q.lim);
  end

  assign bit_free = cmd_q.idx[BIT_W-1:0];
  assign raddr    = (state_q == S_IDLE) ? WIDX_W'(cmd_i.idx >> BIT_W) : word_sel;

  // write-back data and enable
  always_comb begin
    wdata    = cur_word;
    do_write = 1'b0;
    if (state_q == S_DATA && alloc_ok) begin
      wdata    = cur_word | (WORD_BITS'(1) << bit_sel);
      do_write = 1'b1;
    end else if (state_q == S_FREE) begin
      wdata    = cur_word & ~(WORD_BITS'(1) << bit_free);
      do_write = 1'b1;
    end
  end

  // result beat
  always_comb begin
    res_o      = '0;
    res_push_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start && (cmd_i.kind == K_CLEAR || cmd_i.kind == K_REPLY)) begin
          res_push_o  = 1'b1;
          res_o.status = (cmd_i.kind == K_REPLY) ? cmd_i.status : ST_OK;
        end
      end
      S_GRP: begin
        if (!grp_any) begin
          res_push_o   = 1'b1;
          res_o.status = ST_FULL;
        end
      end
      S_DATA: begin
        res_push_o = 1'b1;
        if (alloc_ok) begin
          res_o.id_out = cmd_q.base + alloc_idx[ID_W-1:0];
          res_o.status = ST_OK;
        end else begin
          res_o.status = ST_FULL;
        end
      end
      S_FREE: begin
        res_push_o   = 1'b1;
        res_o.status = ST_OK;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_i.kind)
            K_ALLOC: state_d = S_GRP;
            K_FREE:  state_d = S_FREE;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_GRP:   state_d = grp_any ? S_WORD : S_IDLE;
      S_WORD:  state_d = S_DATA;
      S_DATA:  state_d = S_IDLE;
      S_FREE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state and summary flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      full_q  <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (start && cmd_i.kind == K_CLEAR) begin
        full_q  <= '0;
        valid_q <= '0;
      end else if (do_write) begin
        full_q[word_q]  <= &wdata;
        valid_q[word_q] <= 1'b1;
      end
    end
  end

  // command, search and read-back registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_GRP) begin
      grp_q <= grp_sel;
    end
    if (state_q == S_IDLE || state_q == S_WORD) begin
      word_q <= raddr;
    end
    rdata_q  <= mem_q[raddr];
    rvalid_q <= valid_q[raddr];
  end

  // bitmap memory write port
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[word_q] <= wdata;
    end
  end

  `BIA_ASSERT_IMP(a_push_room, res_push_o, !res_full_i)
  `BIA_ASSERT_IMP(a_alloc_word_not_full, state_q == S_DATA, !full_q[word_q])
  `BIA_ASSERT_NXT(a_clear_empties, start && cmd_i.kind == K_CLEAR, full_q == '0 && valid_q == '0)
  `BIA_ASSERT_IMP(a_done_gives_beat, state_q != S_IDLE && state_d == S_IDLE, res_push_o)

endmodule

// File: src/bitmap_id_allocator.sv
// ---------------------------------------------------------------------------
// bitmap_id_allocator
// first-free identifier allocator over a bitmap of used ids
// ---------------------------------------------------------------------------
// Every input beat gives exactly one result beat, in order. Input beats pass
// through a two-entry command queue into the back end, whose results wait in
// a two-entry result queue. The back end runs one command at a time. Clear,
// unused opcodes and out-of-range releases are answered as the command is
// taken. For a valid release the command is taken with the memory read, then
// the word is written back through the single bitmap memory write port. For
// an allocate the command is taken, then the per-group full summary is
// scanned, then the per-word full summary inside that group is scanned while
// the memory is read, then the lowest free bit is found and written back. An
// allocate on a map whose words are all full ends after the group scan. The
// summary and per-row valid bits are flops cleared by reset and by the clear
// opcode at once, so there is no clearing pass. WORD_BITS must be a power of
// two.
module bitmap_id_allocator
  import bia_pkg::*;
#(
  parameter int unsigned MAP_BITS  = MAP_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  input  in_item_t              in_item_i,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item_o
);

  cmd_t      cmd_in, cmd_out;
  logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
  out_item_t res;
  logic      res_push, res_full;

  // classification front end
  bia_front #(
    .MAP_BITS (MAP_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .full_o      (full),
    .cmd_o       (cmd_in),
    .cmd_push_o  (cmd_push),
    .cmd_full_i  (cmd_full)
  );

  // command queue between front and back
  bia_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // bitmap back end
  bia_back #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result queue towards the consumer
  bia_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule
